/* rtl/core/scalar_kalman_smoother_assert.svh */
// scalar_kalman_smoother_assert.svh: assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef SCALAR_KALMAN_SMOOTHER_ASSERT_SVH
`define SCALAR_KALMAN_SMOOTHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SKF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scalar_kalman_smoother: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scalar_kalman_smoother: assertion failed");

`endif

/* rtl/core/skf_pkg.sv */
// skf_pkg.sv: types, widths and constants of the scalar Kalman smoother.
// No dependencies; used by the interfaces, the divider, the multiplier, the top level and the checker.
package skf_pkg;

    // Field and datapath widths.
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned FRAC_W     = 24;
    localparam int unsigned GAIN_W     = FRAC_W + 1;
    localparam int unsigned DIV_STEPS  = GAIN_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int unsigned MAC_DIG_W  = 16;
    localparam int unsigned MAC_DIGITS = DATA_W / MAC_DIG_W;
    localparam int unsigned MAC_CNT_W  = (MAC_DIGITS > 1) ? $clog2(MAC_DIGITS) : 1;
    localparam int unsigned PROD_W     = 2 * DATA_W;
    // Q16.16 step times Q8.24 noise is Q24.40; this shift brings it to Q24.24.
    localparam int unsigned NOISE_SH   = 16;
    localparam int unsigned NTERM_W    = PROD_W - NOISE_SH;
    localparam int unsigned ESUM_W     = NTERM_W + 1;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic [DATA_W-1:0]        t_q24;
    typedef logic [GAIN_W-1:0]        t_gain;
    typedef logic [DATA_W:0]          t_den;
    typedef logic [PROD_W-1:0]        t_prod;
    typedef logic [NTERM_W-1:0]       t_nterm;
    typedef logic [1:0]               t_cfg_idx;

    // Unity gain in Q1.24.
    localparam t_gain ONE_Q24 = {1'b1, {FRAC_W{1'b0}}};

    // Configuration register indexes.
    localparam t_cfg_idx REG_MEAS_ERR   = 2'd0;
    localparam t_cfg_idx REG_INIT_ERR   = 2'd1;
    localparam t_cfg_idx REG_PROC_NOISE = 2'd2;

    // Reset values of the registers.
    localparam t_q24 MEAS_ERR_RST   = 32'd335544;
    localparam t_q24 INIT_ERR_RST   = 32'd167772;
    localparam t_q24 PROC_NOISE_RST = 32'd33554;

    // Request to the gain divider.
    typedef struct packed {
        logic start;
        t_q24 num;
        t_den den;
    } t_div_req;

    // Request to the shared multiply-accumulate unit.
    typedef struct packed {
        logic start;
        t_q24 mcand;
        t_q24 mplier;
    } t_mac_req;

endpackage

/* rtl/core/skf_in_if.sv */
// skf_in_if.sv: request channel carrying one signed Q16.16 sensor sample.
// Depends on skf_pkg for the sample type.
interface skf_in_if;
    import skf_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/core/skf_out_if.sv */
// skf_out_if.sv: result channel carrying estimate, gain and estimate error.
// Depends on skf_pkg for the field types.
interface skf_out_if;
    import skf_pkg::*;

    logic    valid;
    logic    ready;
    t_sample estimate;
    t_gain   gain;
    t_q24    error_estimate;

    modport source (output valid, output estimate, output gain, output error_estimate,
                    input ready);
    modport sink   (input valid, input estimate, input gain, input error_estimate,
                    output ready);
endinterface

/* rtl/core/skf_div.sv */
// skf_div.sv: restoring divider forming the Q1.24 gain num * 2^24 / den, one bit a cycle.
// Depends on skf_pkg. The caller guarantees num <= den and den != 0.
module skf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  skf_pkg::t_div_req i_req,
    output logic              o_done,
    output skf_pkg::t_gain    o_quot
);
    import skf_pkg::*;

    logic [DATA_W+1:0]    r_rem;
    logic [DATA_W+1:0]    n_rem;
    logic [DATA_W+1:0]    rem_sub;
    t_den                 r_den;
    t_gain                r_quot;
    t_gain                n_quot;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic                 take;

    // One compare-and-subtract step; the remainder always stays below the divisor.
    always_comb begin
        rem_sub = r_rem - {1'b0, r_den};
        take    = (r_rem >= {1'b0, r_den});
        n_rem   = take ? rem_sub : r_rem;
        n_quot  = {r_quot[GAIN_W-2:0], take};
    end

    // Step counter and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
                r_done <= (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
                r_cnt  <= r_cnt + DIV_CNT_W'(1);
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= {2'b00, i_req.num};
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= {n_rem[DATA_W:0], 1'b0};
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

/* rtl/core/skf_mac.sv */
// skf_mac.sv: shared 32 x 32 multiplier built from a 32 x 16 array and an accumulator.
// Depends on skf_pkg. One 16-bit digit of the multiplier is consumed each cycle.
module skf_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  skf_pkg::t_mac_req i_req,
    output logic              o_done,
    output skf_pkg::t_prod    o_prod
);
    import skf_pkg::*;

    t_q24                          r_a;
    t_q24                          r_b;
    t_prod                         r_acc;
    logic [MAC_CNT_W-1:0]          r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [DATA_W+MAC_DIG_W-1:0]   part;
    t_prod                         part_sh;

    // Partial product of the current digit, aligned to its weight.
    always_comb begin
        part    = r_a * r_b[MAC_DIG_W-1:0];
        part_sh = t_prod'(part) << (MAC_DIG_W * r_cnt);
    end

    // Digit counter and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == MAC_CNT_W'(MAC_DIGITS - 1)) begin
                    r_busy <= 1'b0;
                end
                r_done <= (r_cnt == MAC_CNT_W'(MAC_DIGITS - 1));
                r_cnt  <= r_cnt + MAC_CNT_W'(1);
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    // Operand registers and accumulator.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.mcand;
            r_b   <= i_req.mplier;
            r_acc <= '0;
        end else if (r_busy) begin
            r_b   <= r_b >> MAC_DIG_W;
            r_acc <= r_acc + part_sh;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

/* rtl/core/scalar_kalman_smoother.sv */
// Scalar Kalman smoother: one-dimensional adaptive filter for a Q16.16 sensor stream.
// Channels: i_smp takes one sample request (valid/ready); o_res returns the new
// estimate, the gain used and the updated estimate error, one result per sample.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index (0 measurement
// error, 1 initial estimate error, written straight into the running error, 2 process
// noise). Write only while the block is idle; other indexes are ignored.
// Sequence: a sample is accepted only in the idle state, so the block takes no new
// sample until the last one is finished. Each sample goes through the 25-step gain
// divider and then three passes through the shared multiplier; when the gain
// denominator is zero the divider is skipped.
// Stalls: the result sits in an output register; the block accepts the next sample
// while it waits, but cannot complete that sample until the result is taken.
// Reset (synchronous, active low): registers return to their defaults, the estimate
// clears to zero and the running error loads the default initial estimate error.
// Depends on skf_pkg, skf_in_if, skf_out_if, skf_div and skf_mac.
module scalar_kalman_smoother (
    input  logic              i_clk,
    input  logic              i_rst_n,
    skf_in_if.sink            i_smp,
    skf_out_if.source         o_res,
    input  logic              i_cfg_we,
    input  skf_pkg::t_cfg_idx i_cfg_index,
    input  skf_pkg::t_q24     i_cfg_data
);
    import skf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_GAIN,
        S_STEP,
        S_KEEP,
        S_NOISE,
        S_FIN
    } t_state;

    t_state     r_state;
    t_q24       r_meas;
    t_q24       r_noise;
    t_sample    r_prior;
    t_q24       r_err;
    logic       r_out_valid;
    t_sample    r_out_est;
    t_gain      r_out_gain;
    t_q24       r_out_err;

    t_sample    r_sample;
    logic       r_neg;
    t_q24       r_mag;
    t_gain      r_gain;
    t_q24       r_step;
    t_q24       r_keep;
    t_nterm     r_nterm;

    logic [DATA_W:0] sub_sp;
    logic [DATA_W:0] sub_ps;
    t_den            den;
    logic            diff_neg;
    t_q24            diff_mag;
    logic [ESUM_W-1:0] err_sum;
    t_q24            err_sat;
    t_q24            est_next;
    logic            out_free;

    t_div_req   div_req;
    logic       div_done;
    t_gain      div_quot;
    t_mac_req   mac_req;
    logic       mac_done;
    t_prod      mac_prod;

    // Difference from the prior estimate, its sign and magnitude, and the gain denominator.
    always_comb begin
        sub_sp   = {r_sample[DATA_W-1], r_sample} - {r_prior[DATA_W-1], r_prior};
        sub_ps   = {r_prior[DATA_W-1], r_prior} - {r_sample[DATA_W-1], r_sample};
        diff_neg = sub_sp[DATA_W];
        diff_mag = diff_neg ? sub_ps[DATA_W-1:0] : sub_sp[DATA_W-1:0];
        den      = {1'b0, r_err} + {1'b0, r_meas};
    end

    // Final error sum with saturation, and the estimate moved toward the sample.
    always_comb begin
        err_sum  = ESUM_W'(r_keep) + ESUM_W'(r_nterm);
        err_sat  = (err_sum[ESUM_W-1:DATA_W] != '0) ? '1 : err_sum[DATA_W-1:0];
        est_next = r_neg ? t_sample'(t_q24'(r_prior) - r_step)
                         : t_sample'(t_q24'(r_prior) + r_step);
        out_free = !r_out_valid || o_res.ready;
    end

    // Requests to the divider and to the shared multiplier.
    always_comb begin
        div_req.start = (r_state == S_PREP) && (den != '0);
        div_req.num   = r_err;
        div_req.den   = den;

        mac_req.start  = 1'b0;
        mac_req.mcand  = r_mag;
        mac_req.mplier = t_q24'(r_gain);
        case (r_state)
            S_GAIN: begin
                mac_req.start  = 1'b1;
            end
            S_STEP: begin
                mac_req.start  = mac_done;
                mac_req.mcand  = r_err;
                mac_req.mplier = t_q24'(ONE_Q24 - r_gain);
            end
            S_KEEP: begin
                mac_req.start  = mac_done;
                mac_req.mcand  = r_step;
                mac_req.mplier = r_noise;
            end
            default: begin
                mac_req.start  = 1'b0;
            end
        endcase
    end

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    skf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .o_done  (mac_done),
        .o_prod  (mac_prod)
    );

    // Sequencer, filter state, configuration registers and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_meas      <= MEAS_ERR_RST;
            r_noise     <= PROC_NOISE_RST;
            r_prior     <= '0;
            r_err       <= INIT_ERR_RST;
        end else begin
            if (r_out_valid && o_res.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_smp.valid) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= (den == '0) ? S_GAIN : S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (mac_done) begin
                        r_state <= S_KEEP;
                    end
                end
                S_KEEP: begin
                    if (mac_done) begin
                        r_state <= S_NOISE;
                    end
                end
                S_NOISE: begin
                    if (mac_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_prior     <= est_next;
                        r_err       <= err_sat;
                        r_out_valid <= 1'b1;
                        r_out_est   <= est_next;
                        r_out_gain  <= r_gain;
                        r_out_err   <= err_sat;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // The user writes registers only while the block is idle; nothing enforces it.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MEAS_ERR:   r_meas  <= i_cfg_data;
                    REG_INIT_ERR:   r_err   <= i_cfg_data;
                    REG_PROC_NOISE: r_noise <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working registers of the current sample.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_smp.valid) begin
            r_sample <= i_smp.sample;
        end
        if (r_state == S_PREP) begin
            r_neg <= diff_neg;
            r_mag <= diff_mag;
            if (den == '0) begin
                r_gain <= '0;
            end
        end
        if (r_state == S_DIV && div_done) begin
            r_gain <= div_quot;
        end
        if (r_state == S_STEP && mac_done) begin
            r_step <= mac_prod[FRAC_W +: DATA_W];
        end
        if (r_state == S_KEEP && mac_done) begin
            r_keep <= mac_prod[FRAC_W +: DATA_W];
        end
        if (r_state == S_NOISE && mac_done) begin
            r_nterm <= mac_prod[NOISE_SH +: NTERM_W];
        end
    end

    assign i_smp.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.estimate       = r_out_est;
    assign o_res.gain           = r_out_gain;
    assign o_res.error_estimate = r_out_err;
endmodule

/* rtl/core/skf_checker.sv */
// skf_checker.sv: port-level checks of the scalar Kalman smoother, bound to the top level.
// Depends on skf_pkg and scalar_kalman_smoother_assert.svh.
`include "scalar_kalman_smoother_assert.svh"

module skf_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  skf_pkg::t_sample i_out_estimate,
    input  skf_pkg::t_gain   i_out_gain,
    input  skf_pkg::t_q24    i_out_error_estimate
);
    import skf_pkg::*;

    // A stalled result keeps its valid and its payload.
    `SKF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_estimate) && $stable(i_out_gain) && $stable(i_out_error_estimate))

    // The gain never exceeds one.
    `SKF_ASSERT_IMPL(a_gain_range, i_clk, i_rst_n, i_out_valid, i_out_gain <= ONE_Q24)

    // One sample at a time: the block is busy in the cycle after it takes a request.
    `SKF_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
endmodule

bind scalar_kalman_smoother skf_checker u_skf_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_smp.valid),
    .i_in_ready           (i_smp.ready),
    .i_out_valid          (o_res.valid),
    .i_out_ready          (o_res.ready),
    .i_out_estimate       (o_res.estimate),
    .i_out_gain           (o_res.gain),
    .i_out_error_estimate (o_res.error_estimate)
);
